@@ rtl/bnsd_pkg.sv @@
// ----------------------------------------------------------------------------
// bnsd_pkg
// Shared types, codes and helpers for the base-N symbol decoder.
// ----------------------------------------------------------------------------
package bnsd_pkg;

  localparam int CHAR_W  = 8;
  localparam int BLK_W   = 56;
  localparam int NBYTE_W = 3;
  localparam int TOTAL_W = 24;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 24'hFF_FFFF;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_DECODE = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_SYMBOL = 2'd1;
  localparam logic [1:0] ST_BAD_PAD    = 2'd2;

  localparam logic REG_SYMBOL_BITS = 1'b0;
  localparam logic REG_PAD_CHAR    = 1'b1;

  typedef struct packed {
    logic [BLK_W-1:0]   blk;     // bytes left-aligned, MSB first
    logic [NBYTE_W-1:0] nbytes;  // 1..7
    logic [1:0]         status;
    logic [TOTAL_W-1:0] total;   // total shown with the first byte
  } emit_req_t;

  function automatic logic [3:0] eff_bits(input logic [3:0] sb);
    logic [3:0] b;
    b = sb;
    if (sb == 4'd0) b = 4'd1;
    else if (sb > 4'd8) b = 4'd8;
    return b;
  endfunction

  function automatic logic [5:0] block_bits(input logic [3:0] b);
    logic [5:0] bb;
    case (b)
      4'd3, 4'd6: bb = 6'd24;
      4'd5:       bb = 6'd40;
      4'd7:       bb = 6'd56;
      default:    bb = 6'd8;
    endcase
    return bb;
  endfunction

  function automatic logic [3:0] syms_per_block(input logic [3:0] b);
    logic [3:0] n;
    case (b)
      4'd2, 4'd6: n = 4'd4;
      4'd4:       n = 4'd2;
      4'd8:       n = 4'd1;
      default:    n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

@@ rtl/bnsd_emitter.sv @@
// ----------------------------------------------------------------------------
// bnsd_emitter
// Output register that serializes each decoded block request into its bytes.
// ----------------------------------------------------------------------------
module bnsd_emitter (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         req_valid,
  input  bnsd_pkg::emit_req_t          req,
  output logic                         req_ready,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_data_byte,
  output logic [1:0]                   out_status,
  output logic                         out_last,
  output logic [bnsd_pkg::TOTAL_W-1:0] out_total_bytes
);
  import bnsd_pkg::*;

  logic                 valid_r;
  logic [BLK_W-1:0]     blk_r;
  logic [NBYTE_W-1:0]   left_r;
  logic [7:0]           data_r;
  logic [1:0]           status_r;
  logic                 last_r;
  logic [TOTAL_W-1:0]   total_r;
  logic                 take;
  logic [TOTAL_W-1:0]   total_inc;

  assign take      = valid_r && !out_stall;
  assign req_ready = !valid_r || (take && left_r == '0);
  assign total_inc = (total_r == TOTAL_MAX) ? TOTAL_MAX : total_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      left_r  <= '0;
    end else if (req_valid && req_ready) begin
      valid_r  <= 1'b1;
      data_r   <= req.blk[BLK_W-1 -: 8];
      blk_r    <= req.blk << 8;
      left_r   <= req.nbytes - 1'b1;
      last_r   <= (req.nbytes == NBYTE_W'(1));
      status_r <= req.status;
      total_r  <= req.total;
    end else if (take) begin
      if (left_r != '0) begin
        data_r  <= blk_r[BLK_W-1 -: 8];
        blk_r   <= blk_r << 8;
        left_r  <= left_r - 1'b1;
        last_r  <= (left_r == NBYTE_W'(1));
        total_r <= total_inc;
      end else begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_data_byte   = data_r;
  assign out_status      = status_r;
  assign out_last        = last_r;
  assign out_total_bytes = total_r;

endmodule

@@ rtl/base_n_symbol_decoder_top.sv @@
// ----------------------------------------------------------------------------
// base_n_symbol_decoder_top
// Base-N text decoder with a loadable alphabet held in a reverse-map memory.
// ----------------------------------------------------------------------------
// The first result of a request is registered in stage 1, then in the emitter.
// Throughput: one request and one block byte per cycle, each unless stalled.
// A block's bytes never outnumber its symbols, so the byte serializer sets the
// rate only while the output side stalls.
// Reset: synchronous; map valid bits live in flops and all clear together,
// so there is no clearing pass. Registers return to 6 bits and pad '='.
module base_n_symbol_decoder_top #(
  parameter int ALPHABET_DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_command,
  input  logic [7:0]                   in_code_char,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_data_byte,
  output logic [1:0]                   out_status,
  output logic                         out_last,
  output logic [bnsd_pkg::TOTAL_W-1:0] out_total_bytes,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic                         cfg_index,
  input  logic [7:0]                   cfg_data
);
  import bnsd_pkg::*;

  localparam int POS_W = $clog2(ALPHABET_DEPTH + 1);
  localparam int MAP_N = 1 << CHAR_W;

  // configuration
  logic [3:0]        sym_bits_r;
  logic [CHAR_W-1:0] pad_char_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sym_bits_r <= 4'd6;
      pad_char_r <= 8'd61;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SYMBOL_BITS: sym_bits_r <= cfg_data[3:0];
        REG_PAD_CHAR:    pad_char_r <= cfg_data;
        default:         ;
      endcase
    end
  end

  // stage 0: reverse map
  logic [MAP_N-1:0]  map_valid_r;
  logic [CHAR_W-1:0] map_mem [MAP_N];
  logic [CHAR_W-1:0] rd_data_r;
  logic [POS_W-1:0]  next_pos_r;
  logic              in_acc;
  logic              append_ok;
  logic              map_we;

  assign in_acc    = in_valid && !in_stall;
  assign append_ok = in_acc && (in_command == CMD_APPEND) && (in_code_char != '0) &&
                     (next_pos_r < POS_W'(ALPHABET_DEPTH));
  assign map_we    = append_ok && !map_valid_r[in_code_char];

  always_ff @(posedge clk) begin
    if (map_we) map_mem[in_code_char] <= CHAR_W'(next_pos_r);
    if (in_acc) rd_data_r <= map_mem[in_code_char];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
      next_pos_r  <= '0;
    end else if (in_acc && in_command == CMD_CLEAR) begin
      map_valid_r <= '0;
      next_pos_r  <= '0;
    end else if (append_ok) begin
      if (map_we) map_valid_r[in_code_char] <= 1'b1;
      next_pos_r <= next_pos_r + 1'b1;
    end
  end

  // stage 1: block assembly
  logic              s1_valid_r;
  logic [1:0]        s1_cmd_r;
  logic [CHAR_W-1:0] s1_char_r;
  logic              s1_hit_r;

  logic [BLK_W-1:0]   blk_r;
  logic [3:0]         syms_r;
  logic [3:0]         pads_r;
  logic               err_r;
  logic [TOTAL_W-1:0] total_r;

  logic [3:0]         b;
  logic [5:0]         bb;
  logic [3:0]         spb;
  logic [CHAR_W-1:0]  sym_val;
  logic               is_pad;
  logic               is_bad;
  logic [BLK_W-1:0]   blk_new;
  logic [3:0]         syms_new;
  logic [3:0]         pads_new;
  logic               done;
  logic [7:0]         pad_bits;
  logic [NBYTE_W-1:0] nbytes;
  logic               dec_act;
  logic               need_emit;
  logic               s1_blocked;
  logic               s1_go;
  logic [TOTAL_W:0]   total_sum;
  logic [TOTAL_W-1:0] total_add;
  logic [TOTAL_W-1:0] total_one;
  logic [BLK_W-1:0]   blk_aligned;
  emit_req_t          emit_req;
  logic               emit_ready;

  always_comb begin
    b        = eff_bits(sym_bits_r);
    bb       = block_bits(b);
    spb      = syms_per_block(b);
    sym_val  = rd_data_r & CHAR_W'((9'd1 << b) - 9'd1);
    is_pad   = (s1_char_r == pad_char_r);
    is_bad   = !is_pad && ((s1_char_r == '0) || !s1_hit_r);
    blk_new  = (blk_r << b) | (is_pad ? '0 : BLK_W'(sym_val));
    syms_new = syms_r + 1'b1;
    pads_new = pads_r + 4'(is_pad);
    done     = (syms_new >= spb);
    pad_bits = 8'(pads_new) * 8'(b);
    nbytes   = (pad_bits >= {2'b00, bb}) ? '0 : NBYTE_W'(({2'b00, bb} - pad_bits) >> 3);

    case (bb)
      6'd8:    blk_aligned = blk_new << 48;
      6'd24:   blk_aligned = blk_new << 32;
      6'd40:   blk_aligned = blk_new << 16;
      default: blk_aligned = blk_new;
    endcase

    total_sum = {1'b0, total_r} + (TOTAL_W + 1)'(nbytes);
    total_add = (total_sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
    total_one = (total_r == TOTAL_MAX) ? TOTAL_MAX : total_r + 1'b1;

    dec_act    = s1_valid_r && (s1_cmd_r == CMD_DECODE) && !err_r;
    need_emit  = dec_act && (is_bad || done);
    s1_blocked = need_emit && !emit_ready;
    s1_go      = s1_valid_r && !s1_blocked;

    emit_req.blk    = '0;
    emit_req.nbytes = NBYTE_W'(1);
    emit_req.total  = total_r;
    if (is_bad) begin
      emit_req.status = ST_BAD_SYMBOL;
    end else if (nbytes == '0) begin
      emit_req.status = ST_BAD_PAD;
    end else begin
      emit_req.status = ST_OK;
      emit_req.blk    = blk_aligned;
      emit_req.nbytes = nbytes;
      emit_req.total  = total_one;
    end
  end

  assign in_stall = s1_valid_r && s1_blocked;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
    if (in_acc) begin
      s1_cmd_r  <= in_command;
      s1_char_r <= in_code_char;
      s1_hit_r  <= map_valid_r[in_code_char];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_r   <= '0;
      syms_r  <= '0;
      pads_r  <= '0;
      err_r   <= 1'b0;
      total_r <= '0;
    end else if (s1_go && s1_cmd_r == CMD_CLEAR) begin
      blk_r   <= '0;
      syms_r  <= '0;
      pads_r  <= '0;
      err_r   <= 1'b0;
      total_r <= '0;
    end else if (s1_go && dec_act) begin
      if (is_bad) begin
        err_r <= 1'b1;
      end else if (done) begin
        blk_r  <= '0;
        syms_r <= '0;
        pads_r <= '0;
        if (nbytes == '0) err_r <= 1'b1;
        else total_r <= total_add;
      end else begin
        blk_r  <= blk_new;
        syms_r <= syms_new;
        pads_r <= pads_new;
      end
    end
  end

  bnsd_emitter u_emitter (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (s1_go && need_emit),
    .req             (emit_req),
    .req_ready       (emit_ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data_byte   (out_data_byte),
    .out_status      (out_status),
    .out_last        (out_last),
    .out_total_bytes (out_total_bytes)
  );

endmodule

@@ rtl/bnsd_checker.sv @@
// ----------------------------------------------------------------------------
// bnsd_checker
// Port-level checks for the base-N symbol decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bnsd_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [7:0]                   out_data_byte,
  input logic [1:0]                   out_status,
  input logic                         out_last,
  input logic [bnsd_pkg::TOTAL_W-1:0] out_total_bytes
);
  import bnsd_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data_byte) &&
      $stable(out_status) && $stable(out_last) && $stable(out_total_bytes))
    else $error("stalled result changed");

  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_data_byte == 8'd0 && out_last)
    else $error("error result not a single zero byte");

  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid && out_status == ST_OK &&
      (out_total_bytes == $past(out_total_bytes) + 1'b1 ||
       out_total_bytes == TOTAL_MAX))
    else $error("block bytes not consecutive");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind base_n_symbol_decoder_top bnsd_checker u_bnsd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_data_byte   (out_data_byte),
  .out_status      (out_status),
  .out_last        (out_last),
  .out_total_bytes (out_total_bytes)
);
